// ----- hdl/qbh_pkg.sv -----
// shared types and constants of the bicubic heatmap pixel block
package qbh_pkg;

    // field widths of the channels
    localparam int PIX_W      = 16;
    localparam int RECIP_W    = 17;
    localparam int RECIP_FRAC = 16;
    localparam int VAL_W      = 16;
    localparam int HUE_W      = 9;
    localparam int BRIGHT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register reset values
    localparam logic [RECIP_W-1:0] RECIP_RESET = 17'h10000;

    // heatmap constants
    localparam int                 HUE_SCALE    = 359;
    localparam logic [HUE_W-1:0]   HUE_MAX      = 9'd359;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 8'd255;
    localparam int                 BRIGHT_SCALE = 2550;

    // floor(q / 9) as (q * DIV9_MULT) >> DIV9_SHIFT, exact for q below 209717
    localparam int DIV9_SHIFT = 20;
    localparam int DIV9_MULT  = 116509;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAD_LEFT,
        REG_QUAD_TOP,
        REG_WIDTH_RECIP,
        REG_HEIGHT_RECIP,
        REG_VALUE_TL,
        REG_VALUE_TR,
        REG_VALUE_BR,
        REG_VALUE_BL
    } cfg_reg_t;

    // configuration register file contents
    typedef struct packed {
        logic [PIX_W-1:0]          quad_left;
        logic [PIX_W-1:0]          quad_top;
        logic [RECIP_W-1:0]        width_recip;
        logic [RECIP_W-1:0]        height_recip;
        logic signed [VAL_W-1:0]   value_tl;
        logic signed [VAL_W-1:0]   value_tr;
        logic signed [VAL_W-1:0]   value_br;
        logic signed [VAL_W-1:0]   value_bl;
    } cfg_t;

endpackage

// ----- hdl/qbh_intf.sv -----
// channel interfaces: pixel beats in, result beats out, register writes

interface qbh_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [qbh_pkg::PIX_W-1:0]     pixel_x;
    logic [qbh_pkg::PIX_W-1:0]     pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface qbh_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [qbh_pkg::VAL_W-1:0]  surface_value;
    logic [qbh_pkg::HUE_W-1:0]         hue;
    logic [qbh_pkg::BRIGHT_W-1:0]      brightness;

    modport source (output valid, output surface_value, output hue, output brightness,
                    input ready);
    modport sink   (input valid, input surface_value, input hue, input brightness,
                    output ready);
endinterface

interface qbh_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qbh_pkg::CFG_IDX_W-1:0]     index;
    logic [qbh_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/quad_bicubic_heatmap_pixel.sv -----
// top level of the bicubic heatmap pixel block
//
// Usage: the pixel channel takes one (pixel_x, pixel_y) beat per clock and the
// result channel returns one beat per pixel, in order, carrying surface_value
// (Q2.14), hue (0..359) and brightness (0..255). The register channel sets the
// quad origin, the reciprocal width and height (Q1.16) and the four corner
// values; it is always ready and must be written only while no pixel is in
// flight.
// Pipeline from an accepted pixel beat to its result beat: five registered
// stages for the unit coordinate and blend weight, four for the y and x lerps,
// three for hue and brightness.
// Throughput: one pixel per clock if unstalled; each multiplier is registered.
// Reset: all stages empty, origin 0, reciprocals 1.0, corner values 0.
// Stall: when the result channel is not ready the last stage holds its beat;
// empty stages further up keep filling, and pixel ready drops only once every
// stage holds a beat. Nothing is dropped or repeated.
module quad_bicubic_heatmap_pixel #(
    parameter int COORD_BITS      = 16,
    parameter int VALUE_FRAC_BITS = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    qbh_pixel_if.sink       pixel,
    qbh_result_if.source    result,
    qbh_cfg_if.sink         cfg
);

    qbh_pkg::cfg_t cfg_regs;

    logic                              w_valid;
    logic                              w_ready;
    logic [COORD_BITS:0]               wx;
    logic [COORD_BITS:0]               wy;

    logic                              v_valid;
    logic                              v_ready;
    logic signed [qbh_pkg::VAL_W-1:0]  v_value;

    // register file
    qbh_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // unit coordinates and blend weights
    qbh_weight #(
        .COORD_BITS (COORD_BITS)
    ) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .pixel_x   (pixel.pixel_x),
        .pixel_y   (pixel.pixel_y),
        .cfg       (cfg_regs),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .wx        (wx),
        .wy        (wy)
    );

    // bicubic surface value
    qbh_interp #(
        .COORD_BITS (COORD_BITS)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .wx        (wx),
        .wy        (wy),
        .cfg       (cfg_regs),
        .out_valid (v_valid),
        .out_ready (v_ready),
        .value     (v_value)
    );

    // heatmap color
    qbh_heat #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_heat (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (v_valid),
        .in_ready      (v_ready),
        .value         (v_value),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .surface_value (result.surface_value),
        .hue           (result.hue),
        .brightness    (result.brightness)
    );

endmodule

// ----- hdl/qbh_cfg_regs.sv -----
// configuration register file written through the register channel
module qbh_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    qbh_cfg_if.sink         cfg,
    output qbh_pkg::cfg_t   regs
);

    qbh_pkg::cfg_t cfg_reg;
    qbh_pkg::cfg_t cfg_next;

    // always able to take a write
    assign cfg.ready = 1'b1;

    // decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (qbh_pkg::cfg_reg_t'(cfg.index))
                qbh_pkg::REG_QUAD_LEFT:    cfg_next.quad_left    = cfg.data[15:0];
                qbh_pkg::REG_QUAD_TOP:     cfg_next.quad_top     = cfg.data[15:0];
                qbh_pkg::REG_WIDTH_RECIP:  cfg_next.width_recip  = cfg.data[16:0];
                qbh_pkg::REG_HEIGHT_RECIP: cfg_next.height_recip = cfg.data[16:0];
                qbh_pkg::REG_VALUE_TL:     cfg_next.value_tl     = $signed(cfg.data[15:0]);
                qbh_pkg::REG_VALUE_TR:     cfg_next.value_tr     = $signed(cfg.data[15:0]);
                qbh_pkg::REG_VALUE_BR:     cfg_next.value_br     = $signed(cfg.data[15:0]);
                qbh_pkg::REG_VALUE_BL:     cfg_next.value_bl     = $signed(cfg.data[15:0]);
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quad_left    <= '0;
            cfg_reg.quad_top     <= '0;
            cfg_reg.width_recip  <= qbh_pkg::RECIP_RESET;
            cfg_reg.height_recip <= qbh_pkg::RECIP_RESET;
            cfg_reg.value_tl     <= '0;
            cfg_reg.value_tr     <= '0;
            cfg_reg.value_br     <= '0;
            cfg_reg.value_bl     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign regs = cfg_reg;

endmodule

// ----- hdl/qbh_weight.sv -----
// unit coordinate and catmull-rom blend weight for both axes, five stages
module qbh_weight #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [qbh_pkg::PIX_W-1:0]   pixel_x,
    input  logic [qbh_pkg::PIX_W-1:0]   pixel_y,
    input  qbh_pkg::cfg_t               cfg,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_BITS:0]         wx,
    output logic [COORD_BITS:0]         wy
);

    localparam int NS     = 5;
    localparam int PROD_W = qbh_pkg::PIX_W + qbh_pkg::RECIP_W;
    localparam int U_W    = PROD_W + COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = COORD_BITS + 3;
    localparam int H_W    = COORD_BITS + 2;
    localparam logic [U_W-1:0] MAX_U = U_W'((1 << COORD_BITS) - 1);
    localparam logic [H_W-1:0] UNIT  = H_W'(1 << COORD_BITS);

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    // lane 0 is x, lane 1 is y
    logic [qbh_pkg::PIX_W-1:0]   pix    [2];
    logic [qbh_pkg::PIX_W-1:0]   origin [2];
    logic [qbh_pkg::RECIP_W-1:0] recip  [2];

    logic [qbh_pkg::PIX_W-1:0] offs      [2];
    logic [U_W-1:0]            u_full    [2];
    logic [SQ_W-1:0]           sq        [2];
    logic [SQ_W-1:0]           cu        [2];
    logic [SUM_W-1:0]          poly      [2];
    logic [H_W-1:0]            half      [2];

    logic [PROD_W-1:0]         prod_next [2];
    logic [PROD_W-1:0]         prod_reg  [2];
    logic [COORD_BITS-1:0]     t_a_next  [2];
    logic [COORD_BITS-1:0]     t_a_reg   [2];
    logic [COORD_BITS-1:0]     t_b_reg   [2];
    logic [COORD_BITS-1:0]     t2_b_next [2];
    logic [COORD_BITS-1:0]     t2_b_reg  [2];
    logic [COORD_BITS-1:0]     t_c_reg   [2];
    logic [COORD_BITS-1:0]     t2_c_reg  [2];
    logic [COORD_BITS-1:0]     t3_c_next [2];
    logic [COORD_BITS-1:0]     t3_c_reg  [2];
    logic [COORD_BITS:0]       w_next    [2];
    logic [COORD_BITS:0]       w_reg     [2];

    assign pix[0]    = pixel_x;
    assign pix[1]    = pixel_y;
    assign origin[0] = cfg.quad_left;
    assign origin[1] = cfg.quad_top;
    assign recip[0]  = cfg.width_recip;
    assign recip[1]  = cfg.height_recip;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign in_ready = stage_en[0];

    // valid bits follow the data
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // per-lane datapath of all stages
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            // offset from the origin times the reciprocal size
            offs[l]      = (pix[l] >= origin[l]) ? (pix[l] - origin[l]) : '0;
            prod_next[l] = PROD_W'(offs[l]) * PROD_W'(recip[l]);

            // rescale to Q0.COORD_BITS and saturate just below one
            u_full[l]   = (U_W'(prod_reg[l]) << COORD_BITS) >> qbh_pkg::RECIP_FRAC;
            t_a_next[l] = (u_full[l] > MAX_U) ? MAX_U[COORD_BITS-1:0]
                                              : u_full[l][COORD_BITS-1:0];

            // t squared
            sq[l]        = SQ_W'(t_a_reg[l]) * SQ_W'(t_a_reg[l]);
            t2_b_next[l] = sq[l][SQ_W-1:COORD_BITS];

            // t cubed
            cu[l]        = SQ_W'(t2_b_reg[l]) * SQ_W'(t_b_reg[l]);
            t3_c_next[l] = cu[l][SQ_W-1:COORD_BITS];

            // w = (t + 3 t^2 - 2 t^3) / 2, capped at one
            poly[l]   = SUM_W'(t_c_reg[l]) + (SUM_W'(t2_c_reg[l]) << 1)
                      + SUM_W'(t2_c_reg[l]) - (SUM_W'(t3_c_reg[l]) << 1);
            half[l]   = poly[l][SUM_W-1:1];
            w_next[l] = (half[l] > UNIT) ? UNIT[COORD_BITS:0] : half[l][COORD_BITS:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (stage_en[0])
            begin
                prod_reg[l] <= prod_next[l];
            end
            if (stage_en[1])
            begin
                t_a_reg[l] <= t_a_next[l];
            end
            if (stage_en[2])
            begin
                t_b_reg[l]  <= t_a_reg[l];
                t2_b_reg[l] <= t2_b_next[l];
            end
            if (stage_en[3])
            begin
                t_c_reg[l]  <= t_b_reg[l];
                t2_c_reg[l] <= t2_b_reg[l];
                t3_c_reg[l] <= t3_c_next[l];
            end
            if (stage_en[4])
            begin
                w_reg[l] <= w_next[l];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign wx        = w_reg[0];
    assign wy        = w_reg[1];

endmodule

// ----- hdl/qbh_interp.sv -----
// two rounded lerps along y, then one along x with saturation, four stages
module qbh_interp #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COORD_BITS:0]               wx,
    input  logic [COORD_BITS:0]               wy,
    input  qbh_pkg::cfg_t                     cfg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [qbh_pkg::VAL_W-1:0]  value
);

    localparam int NS  = 4;
    localparam int W_W = COORD_BITS + 1;
    localparam int E_W = qbh_pkg::VAL_W + 1;
    localparam int D_W = E_W + 1;
    localparam int S_W = D_W + 1;
    localparam int P_W = E_W + W_W + 1;
    localparam int Q_W = D_W + W_W + 1;
    localparam logic signed [P_W-1:0] HALF_P = P_W'(1 << (COORD_BITS - 1));
    localparam logic signed [Q_W-1:0] HALF_Q = Q_W'(1 << (COORD_BITS - 1));
    localparam logic signed [S_W-1:0] SAT_HI = S_W'(32767);
    localparam logic signed [S_W-1:0] SAT_LO = -S_W'(32768);

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    // lane 0 runs the left column, lane 1 the right column
    logic signed [qbh_pkg::VAL_W-1:0] pa [2];
    logic signed [qbh_pkg::VAL_W-1:0] pb [2];

    logic [E_W-1:0]          da         [2];
    logic signed [P_W-1:0]   rnd_y      [2];
    logic signed [P_W-1:0]   shr_y      [2];
    logic signed [P_W-1:0]   prod_y_next[2];
    logic signed [P_W-1:0]   prod_y_reg [2];
    logic signed [E_W-1:0]   edge_next  [2];
    logic signed [E_W-1:0]   edge_reg   [2];

    logic [COORD_BITS:0]     wx0_reg;
    logic [COORD_BITS:0]     wx1_reg;

    logic [D_W-1:0]          dx;
    logic signed [Q_W-1:0]   prod_x_next;
    logic signed [Q_W-1:0]   prod_x_reg;
    logic signed [E_W-1:0]   top_reg;
    logic signed [Q_W-1:0]   rnd_x;
    logic signed [Q_W-1:0]   shr_x;
    logic signed [S_W-1:0]   sum_x;
    logic signed [qbh_pkg::VAL_W-1:0] value_next;
    logic signed [qbh_pkg::VAL_W-1:0] value_reg;

    assign pa[0] = cfg.value_tl;
    assign pb[0] = cfg.value_bl;
    assign pa[1] = cfg.value_tr;
    assign pb[1] = cfg.value_br;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign in_ready = stage_en[0];

    // valid bits follow the data
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // lerps along y: product, then round, shift and add the start value
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            da[l]          = {pb[l][qbh_pkg::VAL_W-1], pb[l]} - {pa[l][qbh_pkg::VAL_W-1], pa[l]};
            prod_y_next[l] = $signed({{(P_W-E_W){da[l][E_W-1]}}, da[l]})
                           * $signed({{(P_W-W_W){1'b0}}, wy});
            rnd_y[l]       = prod_y_reg[l] + HALF_P;
            shr_y[l]       = rnd_y[l] >>> COORD_BITS;
            edge_next[l]   = {pa[l][qbh_pkg::VAL_W-1], pa[l]} + shr_y[l][E_W-1:0];
        end
    end

    // lerp along x
    always_comb
    begin
        dx          = {edge_reg[1][E_W-1], edge_reg[1]} - {edge_reg[0][E_W-1], edge_reg[0]};
        prod_x_next = $signed({{(Q_W-D_W){dx[D_W-1]}}, dx})
                    * $signed({{(Q_W-W_W){1'b0}}, wx1_reg});
        rnd_x       = prod_x_reg + HALF_Q;
        shr_x       = rnd_x >>> COORD_BITS;
        sum_x       = {{(S_W-E_W){top_reg[E_W-1]}}, top_reg} + shr_x[S_W-1:0];
        if (sum_x > SAT_HI)
        begin
            value_next = SAT_HI[qbh_pkg::VAL_W-1:0];
        end
        else if (sum_x < SAT_LO)
        begin
            value_next = SAT_LO[qbh_pkg::VAL_W-1:0];
        end
        else
        begin
            value_next = sum_x[qbh_pkg::VAL_W-1:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            prod_y_reg[0] <= prod_y_next[0];
            prod_y_reg[1] <= prod_y_next[1];
            wx0_reg       <= wx;
        end
        if (stage_en[1])
        begin
            edge_reg[0] <= edge_next[0];
            edge_reg[1] <= edge_next[1];
            wx1_reg     <= wx0_reg;
        end
        if (stage_en[2])
        begin
            prod_x_reg <= prod_x_next;
            top_reg    <= edge_reg[0];
        end
        if (stage_en[3])
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign value     = value_reg;

endmodule

// ----- hdl/qbh_heat.sv -----
// heatmap hue and brightness from the surface value, three stages
module qbh_heat #(
    parameter int VALUE_FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qbh_pkg::VAL_W-1:0]    value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qbh_pkg::VAL_W-1:0]    surface_value,
    output logic [qbh_pkg::HUE_W-1:0]           hue,
    output logic [qbh_pkg::BRIGHT_W-1:0]        brightness
);

    localparam int NS     = 3;
    localparam int VW     = qbh_pkg::VAL_W;
    localparam int DIFF_W = ((VALUE_FRAC_BITS > VW - 1) ? VALUE_FRAC_BITS : VW - 1) + 2;
    localparam int HP_W   = DIFF_W + 10;
    localparam int TH_W   = ((VALUE_FRAC_BITS + 5) > 21) ? (VALUE_FRAC_BITS + 5) : 21;
    localparam int BP_W   = 27;
    localparam int Q_W    = 19;
    localparam int QM_W   = Q_W + 17;
    localparam int B_W    = QM_W - qbh_pkg::DIV9_SHIFT;
    localparam logic signed [DIFF_W-1:0] ONE      = DIFF_W'(1 << VALUE_FRAC_BITS);
    localparam logic signed [HP_W-1:0]   HUE_K    = HP_W'(qbh_pkg::HUE_SCALE);
    localparam logic signed [TH_W-1:0]   NINE_ONE = TH_W'(9 << VALUE_FRAC_BITS);

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    // stage 0 signals
    logic signed [DIFF_W-1:0] diff;
    logic signed [TH_W-1:0]   v_th;
    logic signed [TH_W-1:0]   v10;
    logic signed [HP_W-1:0]   hue_prod_next;
    logic signed [HP_W-1:0]   hue_prod_reg;
    logic [BP_W-1:0]          bprod_next;
    logic [BP_W-1:0]          bprod_reg;
    logic                     high_next;
    logic                     high_a_reg;
    logic                     pos_next;
    logic                     pos_a_reg;
    logic signed [VW-1:0]     v_a_reg;

    // stage 1 signals
    logic [HP_W-1:0]          hq;
    logic [Q_W-1:0]           q;
    logic [qbh_pkg::HUE_W-1:0] hue_next;
    logic [qbh_pkg::HUE_W-1:0] hue_b_reg;
    logic [QM_W-1:0]          qm_next;
    logic [QM_W-1:0]          qm_reg;
    logic                     high_b_reg;
    logic                     pos_b_reg;
    logic signed [VW-1:0]     v_b_reg;

    // stage 2 signals
    logic [B_W-1:0]              bq;
    logic [qbh_pkg::BRIGHT_W-1:0] bright_next;
    logic [qbh_pkg::BRIGHT_W-1:0] bright_reg;
    logic [qbh_pkg::HUE_W-1:0]    hue_reg;
    logic signed [VW-1:0]         v_reg;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign in_ready = stage_en[0];

    // valid bits follow the data
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // products for hue and brightness, threshold at 0.9
    always_comb
    begin
        diff          = ONE - $signed({{(DIFF_W-VW){value[VW-1]}}, value});
        hue_prod_next = $signed({{(HP_W-DIFF_W){diff[DIFF_W-1]}}, diff}) * HUE_K;
        v_th          = $signed({{(TH_W-VW){value[VW-1]}}, value});
        v10           = (v_th <<< 3) + (v_th <<< 1);
        high_next     = (v10 >= NINE_ONE);
        pos_next      = !value[VW-1] && (value != '0);
        bprod_next    = BP_W'(value[VW-2:0]) * BP_W'(qbh_pkg::BRIGHT_SCALE);
    end

    // hue clamp and divide by nine via reciprocal
    always_comb
    begin
        hq = hue_prod_reg >> VALUE_FRAC_BITS;
        if (hue_prod_reg[HP_W-1] || (hue_prod_reg == '0))
        begin
            hue_next = '0;
        end
        else if (hq > HP_W'(qbh_pkg::HUE_SCALE))
        begin
            hue_next = qbh_pkg::HUE_MAX;
        end
        else
        begin
            hue_next = hq[qbh_pkg::HUE_W-1:0];
        end
        q       = Q_W'(bprod_reg >> VALUE_FRAC_BITS);
        qm_next = QM_W'(q) * QM_W'(qbh_pkg::DIV9_MULT);
    end

    // brightness select
    always_comb
    begin
        bq = qm_reg[QM_W-1:qbh_pkg::DIV9_SHIFT];
        if (high_b_reg)
        begin
            bright_next = qbh_pkg::BRIGHT_MAX;
        end
        else if (!pos_b_reg)
        begin
            bright_next = '0;
        end
        else if (bq > B_W'(qbh_pkg::BRIGHT_MAX))
        begin
            bright_next = qbh_pkg::BRIGHT_MAX;
        end
        else
        begin
            bright_next = bq[qbh_pkg::BRIGHT_W-1:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            hue_prod_reg <= hue_prod_next;
            bprod_reg    <= bprod_next;
            high_a_reg   <= high_next;
            pos_a_reg    <= pos_next;
            v_a_reg      <= value;
        end
        if (stage_en[1])
        begin
            hue_b_reg  <= hue_next;
            qm_reg     <= qm_next;
            high_b_reg <= high_a_reg;
            pos_b_reg  <= pos_a_reg;
            v_b_reg    <= v_a_reg;
        end
        if (stage_en[2])
        begin
            bright_reg <= bright_next;
            hue_reg    <= hue_b_reg;
            v_reg      <= v_b_reg;
        end
    end

    assign out_valid     = valid_reg[NS-1];
    assign surface_value = v_reg;
    assign hue           = hue_reg;
    assign brightness    = bright_reg;

endmodule
